/* hw/rtl/sha1_stream_hasher_assert.svh */
// Assertion macros for the SHA-1 stream hasher. They expect clk and rst in scope.
`ifndef SHA1_STREAM_HASHER_ASSERT_SVH
`define SHA1_STREAM_HASHER_ASSERT_SVH

`define SHA1_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha1 stream hasher: same-cycle check failed");

`define SHA1_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha1 stream hasher: next-cycle check failed");

`endif

/* hw/rtl/sha1_pkg.sv */
package sha1_pkg;

  localparam int BLOCK_BYTES  = 64;
  localparam int LEN_POS      = 56;
  localparam int ROUNDS       = 80;
  localparam int DIGEST_WORDS = 5;

  localparam logic [31:0] IV [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic push_msg;
    logic push_pad;
    logic pad_mark;
    logic pad_len;
    logic load_vars;
    logic round_step;
    logic chain_add;
    logic emit_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_ge56;
    logic round_last;
    logic word_last;
  } stat_t;

endpackage

/* hw/rtl/sha1_if.sv */
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_message, input ready);
  modport sink (input valid, input data_byte, input byte_valid,
                input end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

/* hw/rtl/sha1_dp.sv */
module sha1_dp (
  input  logic           clk,
  input  logic           rst,
  input  sha1_pkg::cmd_t cmd,
  output sha1_pkg::stat_t stat,
  input  logic [7:0]     data_byte,
  output logic [31:0]    digest_word,
  output logic [2:0]     word_index,
  output logic           last_word
);
  import sha1_pkg::*;

  logic [511:0] window;
  logic [5:0]   fill;
  logic [60:0]  count;
  logic [31:0]  h [DIGEST_WORDS];
  logic [31:0]  v [DIGEST_WORDS];
  logic [6:0]   round;
  logic [2:0]   word_idx;

  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic [7:0]  byte_in;
  logic        push;
  logic [31:0] w_now;
  logic [31:0] w_mix;
  logic [31:0] w_new;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  assign len_bits = {count, 3'b000};
  assign len_byte = len_bits[{~fill[2:0], 3'b000} +: 8];
  assign push     = cmd.push_msg | cmd.push_pad;

  always_comb begin
    if (cmd.push_msg) begin
      byte_in = data_byte;
    end else if (cmd.pad_mark) begin
      byte_in = PAD_MARK;
    end else if (cmd.pad_len) begin
      byte_in = len_byte;
    end else begin
      byte_in = 8'h00;
    end
  end

  assign w_now = window[511:480];
  assign w_mix = window[95:64] ^ window[255:224] ^ window[447:416] ^ window[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (round < 7'd20) begin
      f = (v[1] & v[2]) | (~v[1] & v[3]);
      k = K0;
    end else if (round < 7'd40) begin
      f = v[1] ^ v[2] ^ v[3];
      k = K1;
    end else if (round < 7'd60) begin
      f = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]);
      k = K2;
    end else begin
      f = v[1] ^ v[2] ^ v[3];
      k = K3;
    end
    t = {v[0][26:0], v[0][31:27]} + f + v[4] + k + w_now;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      window <= {window[503:0], byte_in};
    end else if (cmd.round_step) begin
      window <= {window[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        v[i] <= h[i];
      end
    end else if (cmd.round_step) begin
      v[0] <= t;
      v[1] <= v[0];
      v[2] <= {v[1][1:0], v[1][31:2]};
      v[3] <= v[2];
      v[4] <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      count    <= '0;
      round    <= '0;
      word_idx <= '0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        h[i] <= IV[i];
      end
    end else begin
      if (push) begin
        fill <= fill + 6'd1;
      end
      if (cmd.finish) begin
        count <= '0;
      end else if (cmd.push_msg) begin
        count <= count + 61'd1;
      end
      if (cmd.load_vars) begin
        round <= '0;
      end else if (cmd.round_step) begin
        round <= round + 7'd1;
      end
      if (cmd.finish) begin
        word_idx <= '0;
      end else if (cmd.emit_step) begin
        word_idx <= word_idx + 3'd1;
      end
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        if (cmd.finish) begin
          h[i] <= IV[i];
        end else if (cmd.chain_add) begin
          h[i] <= h[i] + v[i];
        end
      end
    end
  end

  always_comb begin
    case (word_idx)
      3'd1:    digest_word = h[1];
      3'd2:    digest_word = h[2];
      3'd3:    digest_word = h[3];
      3'd4:    digest_word = h[4];
      default: digest_word = h[0];
    endcase
  end

  assign word_index = word_idx;
  assign last_word  = (word_idx == 3'(DIGEST_WORDS - 1));

  assign stat.fill_last  = (fill == 6'(BLOCK_BYTES - 1));
  assign stat.fill_ge56  = (fill >= 6'(LEN_POS));
  assign stat.round_last = (round == 7'(ROUNDS - 1));
  assign stat.word_last  = last_word;

endmodule

/* hw/rtl/sha1_ctrl.sv */
module sha1_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_byte_valid,
  input  logic            in_eom,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sha1_pkg::stat_t stat,
  output sha1_pkg::cmd_t  cmd
);
  import sha1_pkg::*;

  state_t state, state_next;
  logic padding, padding_next;
  logic pad_first, pad_first_next;
  logic len_ok, len_ok_next;
  logic final_blk, final_blk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      padding   <= 1'b0;
      pad_first <= 1'b0;
      len_ok    <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state     <= state_next;
      padding   <= padding_next;
      pad_first <= pad_first_next;
      len_ok    <= len_ok_next;
      final_blk <= final_blk_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid && stat.fill_last) begin
            state_next = S_ROUND;
          end else if (in_eom) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (stat.fill_last) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (stat.round_last) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        if (final_blk) begin
          state_next = S_EMIT;
        end else if (padding) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_ready && stat.word_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.push_msg  = in_valid & in_byte_valid;
        cmd.load_vars = in_valid & in_byte_valid & stat.fill_last;
      end
      S_PAD: begin
        cmd.push_pad  = 1'b1;
        cmd.pad_mark  = pad_first;
        cmd.pad_len   = ~pad_first & len_ok & stat.fill_ge56;
        cmd.load_vars = stat.fill_last;
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
      end
      S_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_step = out_ready & ~stat.word_last;
        cmd.finish    = out_ready & stat.word_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    padding_next   = padding;
    pad_first_next = pad_first;
    len_ok_next    = len_ok;
    final_blk_next = final_blk;
    case (state)
      S_IDLE: begin
        if (in_valid && in_eom) begin
          padding_next   = 1'b1;
          pad_first_next = 1'b1;
          len_ok_next    = 1'b0;
          final_blk_next = 1'b0;
        end
      end
      S_PAD: begin
        pad_first_next = 1'b0;
        if (pad_first && !stat.fill_ge56) begin
          len_ok_next = 1'b1;
        end
        if (stat.fill_last && len_ok && !pad_first) begin
          final_blk_next = 1'b1;
        end
      end
      S_ADD: begin
        if (final_blk) begin
          padding_next   = 1'b0;
          len_ok_next    = 1'b0;
          final_blk_next = 1'b0;
        end else if (padding && !pad_first) begin
          len_ok_next = 1'b1;
        end
      end
      default: begin
        padding_next = padding;
      end
    endcase
  end

endmodule

/* hw/rtl/sha1_stream_hasher.sv */
// SHA-1 over a byte stream.
// The msg channel takes one beat per item: data_byte with byte_valid, and
// end_of_message on the final beat of a message (it may carry no byte).
// The digest channel gives five beats per message, h0 to h4, with
// word_index and last_word marking the fifth beat.
// A beat that completes a 64-byte block starts an 80-round compression at
// one round per cycle, then the chain add; other message beats are taken
// without a stall. After the end-of-message beat, padding bytes are fed in
// one per cycle and one or two blocks are compressed before the first
// digest beat; the five beats then go out one per cycle while digest.ready
// is high. msg.ready stays low from a full block until its compression is
// done, and while padding or delivering the digest; a stalled digest beat
// holds. Reset loads the initial chain value and clears the byte count;
// the block then takes a new message at once.
`include "sha1_stream_hasher_assert.svh"

module sha1_stream_hasher (
  input logic        clk,
  input logic        rst,
  sha1_in_if.sink    msg,
  sha1_out_if.source digest
);
  import sha1_pkg::*;

  localparam logic [2:0] LAST_IDX = 3'(DIGEST_WORDS - 1);

  cmd_t  cmd;
  stat_t stat;

  logic       mid_fire;
  logic       end_fire;
  logic [2:0] idx_next;

  sha1_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (msg.valid),
    .in_byte_valid (msg.byte_valid),
    .in_eom        (msg.end_of_message),
    .in_ready      (msg.ready),
    .out_valid     (digest.valid),
    .out_ready     (digest.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  sha1_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .data_byte   (msg.data_byte),
    .digest_word (digest.digest_word),
    .word_index  (digest.word_index),
    .last_word   (digest.last_word)
  );

  assign mid_fire = digest.valid & digest.ready & ~digest.last_word;
  assign end_fire = digest.valid & digest.ready & digest.last_word;
  assign idx_next = digest.word_index + 3'd1;

  `SHA1_ASSERT_IMPL(a_no_overlap, digest.valid, !msg.ready)
  `SHA1_ASSERT_IMPL(a_last_mark, digest.valid, digest.last_word == (digest.word_index == LAST_IDX))
  `SHA1_ASSERT_NEXT(a_words_follow, mid_fire, digest.valid && digest.word_index == $past(idx_next))
  `SHA1_ASSERT_NEXT(a_back_to_idle, end_fire, msg.ready && !digest.valid && digest.word_index == 3'd0)

endmodule

/* dv/sha1_stream_hasher_test.sv */
`timescale 1ns / 1ps

module sha1_stream_hasher_test;
  import sha1_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TARGET_ITEMS = 450;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } msg_item_t;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha1_in_if  msg_if ();
  sha1_out_if digest_if ();

  sha1_stream_hasher u_dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if),
    .digest (digest_if)
  );

  always #2 clk = ~clk;

  msg_item_t    msg_items [$];
  digest_beat_t digest_due [$];

  logic [31:0] chain_h [DIGEST_WORDS];
  logic [7:0]  block_bytes [BLOCK_BYTES];
  logic [60:0] msg_len;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;
  int   in_hold = 0;
  int   out_hold = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;
  int   item_count = 0;

  initial begin
    msg_if.valid = 1'b0;
    msg_if.data_byte = 8'h00;
    msg_if.byte_valid = 1'b0;
    msg_if.end_of_message = 1'b0;
    digest_if.ready = 1'b0;
    chain_h = IV;
    msg_len = '0;
  end

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int j = 0; j < 16; j++) begin
      w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2], block_bytes[4*j+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int j = 0; j < ROUNDS; j++) begin
      if (j >= 16) begin
        x = w[(j + 13) % 16] ^ w[(j + 8) % 16] ^ w[(j + 2) % 16] ^ w[j % 16];
        w[j % 16] = {x[30:0], x[31]};
      end
      if (j < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (j < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (j < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[j % 16];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void absorb_item(msg_item_t it);
    int pos;
    logic [63:0] bit_len;
    digest_beat_t beat;
    if (it.byte_valid) begin
      block_bytes[msg_len[5:0]] = it.data_byte;
      msg_len++;
      if (msg_len[5:0] == 6'd0) begin
        compress_block();
      end
    end
    if (!it.end_of_message) begin
      return;
    end
    pos = msg_len[5:0];
    block_bytes[pos] = PAD_MARK;
    for (int i = pos + 1; i < BLOCK_BYTES; i++) begin
      block_bytes[i] = 8'h00;
    end
    if (pos >= LEN_POS) begin
      compress_block();
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        block_bytes[i] = 8'h00;
      end
    end
    bit_len = {msg_len, 3'b000};
    for (int i = 0; i < 8; i++) begin
      block_bytes[LEN_POS + i] = bit_len[63 - 8*i -: 8];
    end
    compress_block();
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      beat.digest_word = chain_h[i];
      beat.word_index = 3'(i);
      beat.last_word = (i == DIGEST_WORDS - 1);
      digest_due.push_back(beat);
    end
    chain_h = IV;
    msg_len = '0;
  endfunction

  function automatic void add_item(logic [7:0] data, logic bv, logic eom);
    msg_item_t it;
    it.data_byte = data;
    it.byte_valid = bv;
    it.end_of_message = eom;
    msg_items.push_back(it);
    if (bv || eom) begin
      item_count++;
    end
  endfunction

  function automatic void add_message(int len, bit eom_with_byte, int noise_pct);
    int n;
    n = (eom_with_byte && len > 0) ? len - 1 : len;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        add_item(8'($urandom), 1'b0, 1'b0);
      end
      add_item(8'($urandom), 1'b1, 1'b0);
    end
    if (eom_with_byte && len > 0) begin
      add_item(8'($urandom), 1'b1, 1'b1);
    end else begin
      add_item(8'($urandom), 1'b0, 1'b1);
    end
  endfunction

  initial begin
    int r;
    int len;
    int boundary [6] = '{55, 56, 57, 63, 64, 65};

    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'hFF, 1'b0, 1'b0);
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);
    add_item(8'h63, 1'b1, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);
    add_item(8'hFF, 1'b1, 1'b1);
    add_item(8'h5A, 1'b1, 1'b0);
    add_item(8'hA5, 1'b0, 1'b0);
    add_item(8'hFF, 1'b0, 1'b1);
    add_item(8'hFF, 1'b1, 1'b0);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);

    while (item_count < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        len = $urandom_range(0, 10);
      end else if (r < 80) begin
        len = boundary[$urandom_range(0, 5)];
      end else if (r < 92) begin
        len = $urandom_range(11, 54);
      end else begin
        len = $urandom_range(66, 140);
      end
      add_message(len, $urandom_range(0, 1), ($urandom_range(0, 9) == 0) ? 10 : 0);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (msg_items.size() > 0 || msg_if.valid) begin
      @(posedge clk);
    end
    while (digest_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && digest_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin
    msg_item_t    seen;
    digest_beat_t want;
    in_fire = !rst && msg_if.valid && msg_if.ready;
    out_fire = !rst && digest_if.valid && digest_if.ready;
    if (in_fire) begin
      seen.data_byte = msg_if.data_byte;
      seen.byte_valid = msg_if.byte_valid;
      seen.end_of_message = msg_if.end_of_message;
      absorb_item(seen);
    end
    if (out_fire) begin
      if (digest_due.size() == 0) begin
        report_mismatch($sformatf("unexpected digest beat %h index %0d",
                                  digest_if.digest_word, digest_if.word_index));
      end else begin
        want = digest_due.pop_front();
        if (digest_if.digest_word !== want.digest_word) begin
          report_mismatch($sformatf("word %0d: digest_word %h, predicted %h", want.word_index,
                                    digest_if.digest_word, want.digest_word));
        end
        if (digest_if.word_index !== want.word_index) begin
          report_mismatch($sformatf("word_index %0d, predicted %0d",
                                    digest_if.word_index, want.word_index));
        end
        if (digest_if.last_word !== want.last_word) begin
          report_mismatch($sformatf("word %0d: last_word %b, predicted %b", want.word_index,
                                    digest_if.last_word, want.last_word));
        end
      end
    end
    if (!rst) begin
      idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TIMEOUT at %0t ns: no beat for %0d cycles", $time, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    msg_item_t nxt;
    if (!rst && (!msg_if.valid || in_fire)) begin
      if (in_fire) begin
        if ($urandom_range(0, 99) < 3) begin
          in_calm = !in_calm;
        end
        in_hold = pick_gap(in_calm);
      end
      if (in_hold > 0 || msg_items.size() == 0) begin
        msg_if.valid <= 1'b0;
        if (in_hold > 0) begin
          in_hold--;
        end
      end else begin
        nxt = msg_items.pop_front();
        msg_if.data_byte <= nxt.data_byte;
        msg_if.byte_valid <= nxt.byte_valid;
        msg_if.end_of_message <= nxt.end_of_message;
        msg_if.valid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (out_fire) begin
        if ($urandom_range(0, 99) < 3) begin
          out_calm = !out_calm;
        end
        out_hold = pick_gap(out_calm);
      end else if (out_hold == 0 && !out_calm && $urandom_range(0, 99) < 2) begin
        out_hold = pick_gap(1'b0);
      end
      if (out_hold > 0) begin
        digest_if.ready <= 1'b0;
        out_hold--;
      end else begin
        digest_if.ready <= 1'b1;
      end
    end
  end

endmodule
